@@ hdl/vmt_pkg.sv @@
// Package for the vector matrix transform core.
// Holds command codes, lane status type and configuration reset values.
// No dependencies.
package vmt_pkg;

  typedef enum logic [2:0] {
    CMD_FULL3D = 3'd0,
    CMD_SIMPLE = 3'd1,
    CMD_COORD  = 3'd2,
    CMD_NORMAL = 3'd3,
    CMD_FULL4D = 3'd4
  } cmd_t;

  typedef struct packed {
    logic sat;
    logic zero;
  } lane_flags_t;

  localparam int CFG_REGS   = 8;
  localparam int CFG_ADDR_W = 6;
  localparam int CFG_DATA_W = 64;
  localparam int FIELD_W    = 32;

  localparam logic [CFG_DATA_W-1:0] CFG_RESET [CFG_REGS] = '{
    64'h0000_0001_0000_0000,
    64'h0,
    64'h0,
    64'h0,
    64'h0,
    64'h0000_0000_0001_0000,
    64'h0,
    64'h0001_0000_0000_0000
  };

endpackage

@@ hdl/vmt_intf.sv @@
// Valid/ready channel interfaces for the vector matrix transform core.
// Depends on nothing; the input word carries a command and a vector.
interface vmt_in_if;
  logic               valid;
  logic               ready;
  logic [2:0]         command;
  logic signed [31:0] vec_x;
  logic signed [31:0] vec_y;
  logic signed [31:0] vec_z;
  logic signed [31:0] vec_w;

  modport source (output valid, command, vec_x, vec_y, vec_z, vec_w, input ready);
  modport sink (input valid, command, vec_x, vec_y, vec_z, vec_w, output ready);
endinterface

interface vmt_out_if;
  logic               valid;
  logic               ready;
  logic signed [31:0] out_x;
  logic signed [31:0] out_y;
  logic signed [31:0] out_z;
  logic signed [31:0] out_w;
  logic               zero_divisor;
  logic               saturated;

  modport source (output valid, out_x, out_y, out_z, out_w, zero_divisor, saturated,
                  input ready);
  modport sink (input valid, out_x, out_y, out_z, out_w, zero_divisor, saturated,
                output ready);
endinterface

@@ hdl/vector_matrix_transform_core.sv @@
// Top level of the vector matrix transform core.
// Depends on vmt_pkg, vmt_intf, vmt_lane and vmt_div.
//
// Usage: the vec channel takes one word per cycle holding a command and a
// signed fixed point vector; the res channel returns one word per input word
// with four saturated components and the zero divisor and saturated flags.
// The matrix lives in eight 64-bit registers on the APB port at byte address
// 8*i; writes land when psel, penable and pwrite are high, and reads return
// the register value. Write them only while the core is empty.
// Four column lanes compute the dot products in parallel, a merging stage
// prepares the coordinate divide, three pipelined dividers run one quotient
// bit per stage, and a final stage selects the mode's results.
// Throughput is one word per cycle. The whole pipeline advances together;
// when the receiver stalls with a result waiting, ready drops and every
// stage holds. Reset empties the pipeline and loads the matrix registers
// with their reset values.
module vector_matrix_transform_core #(
  parameter int COMP_WIDTH = 32,
  parameter int FRAC_BITS  = 16
) (
  input  logic                                clk,
  input  logic                                rst,
  vmt_in_if.sink                              vec,
  vmt_out_if.source                           res,
  input  logic                                psel,
  input  logic                                penable,
  input  logic                                pwrite,
  input  logic [vmt_pkg::CFG_ADDR_W-1:0]      paddr,
  input  logic [vmt_pkg::CFG_DATA_W-1:0]      pwdata,
  output logic [vmt_pkg::CFG_DATA_W-1:0]      prdata,
  output logic                                pready
);

  localparam int CW = COMP_WIDTH;
  localparam int FB = FRAC_BITS;
  localparam int NW = CW + FB + 1;
  localparam int D  = NW + 5;

  typedef struct packed {
    logic [2:0]            cmd;
    logic signed [CW-1:0]  x;
    logic signed [CW-1:0]  y;
    logic signed [CW-1:0]  z;
    logic signed [CW-1:0]  w;
    vmt_pkg::lane_flags_t  fx;
    vmt_pkg::lane_flags_t  fy;
    vmt_pkg::lane_flags_t  fz;
    vmt_pkg::lane_flags_t  fw;
  } aux_t;

  logic [vmt_pkg::CFG_DATA_W-1:0] cfg [vmt_pkg::CFG_REGS];
  logic [2:0] cidx;
  logic en;

  assign cidx   = paddr[5:3];
  assign pready = 1'b1;
  assign prdata = cfg[cidx];

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < vmt_pkg::CFG_REGS; i++) begin
        cfg[i] <= vmt_pkg::CFG_RESET[i];
      end
    end else if (psel && penable && pwrite) begin
      cfg[cidx] <= pwdata;
    end
  end

  assign en        = !res.valid || res.ready;
  assign vec.ready = en;

  logic v [D];
  logic [2:0] cmd_p [3];

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < D; i++) begin
        v[i] <= 1'b0;
      end
    end else if (en) begin
      v[0] <= vec.valid;
      for (int i = 1; i < D; i++) begin
        v[i] <= v[i-1];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      cmd_p[0] <= vec.command;
      cmd_p[1] <= cmd_p[0];
      cmd_p[2] <= cmd_p[1];
    end
  end

  logic signed [CW-1:0] lval [4];
  vmt_pkg::lane_flags_t lflg [4];

  generate
    for (genvar c = 0; c < 4; c++) begin : g_lane
      vmt_lane #(.CW(CW), .FB(FB)) u_lane (
        .clk   (clk),
        .en    (en),
        .cmd   (vec.command),
        .vx    (vec.vec_x[CW-1:0]),
        .vy    (vec.vec_y[CW-1:0]),
        .vz    (vec.vec_z[CW-1:0]),
        .vw    (vec.vec_w[CW-1:0]),
        .c1    (cfg[0 + c/2][(c%2)*32 +: CW]),
        .c2    (cfg[2 + c/2][(c%2)*32 +: CW]),
        .c3    (cfg[4 + c/2][(c%2)*32 +: CW]),
        .c4    (cfg[6 + c/2][(c%2)*32 +: CW]),
        .val   (lval[c]),
        .flags (lflg[c])
      );
    end
  endgenerate

  logic [CW-1:0] dabs;
  logic [CW-1:0] dreg;
  logic [NW-1:0] nreg [3];
  logic          greg [3];
  logic signed [CW-1:0] qv [3];
  logic          qs [3];
  aux_t aux_d [NW+2];

  assign dabs = lval[3][CW-1] ? -lval[3] : lval[3];

  generate
    for (genvar c = 0; c < 3; c++) begin : g_div
      logic [CW-1:0] nabs;
      assign nabs = lval[c][CW-1] ? -lval[c] : lval[c];
      always_ff @(posedge clk) begin
        if (en) begin
          nreg[c] <= NW'({nabs, {FB{1'b0}}}) + NW'(dabs >> 1);
          greg[c] <= lval[c][CW-1] ^ lval[3][CW-1];
        end
      end
      vmt_div #(.CW(CW), .FB(FB)) u_div (
        .clk (clk),
        .en  (en),
        .num (nreg[c]),
        .den (dreg),
        .neg (greg[c]),
        .val (qv[c]),
        .sat (qs[c])
      );
    end
  endgenerate

  always_ff @(posedge clk) begin
    if (en) begin
      dreg         <= dabs;
      aux_d[0].cmd <= cmd_p[2];
      aux_d[0].x   <= lval[0];
      aux_d[0].y   <= lval[1];
      aux_d[0].z   <= lval[2];
      aux_d[0].w   <= lval[3];
      aux_d[0].fx  <= lflg[0];
      aux_d[0].fy  <= lflg[1];
      aux_d[0].fz  <= lflg[2];
      aux_d[0].fw  <= lflg[3];
      for (int i = 1; i < NW + 2; i++) begin
        aux_d[i] <= aux_d[i-1];
      end
    end
  end

  aux_t a;
  logic signed [CW-1:0] ox, oy, oz, ow;
  logic ozd, osat;

  assign a = aux_d[NW+1];

  always_comb begin
    ox = '0;
    oy = '0;
    oz = '0;
    ow = '0;
    ozd = 1'b0;
    osat = 1'b0;
    case (a.cmd)
      vmt_pkg::CMD_FULL3D, vmt_pkg::CMD_FULL4D: begin
        ox = a.x;
        oy = a.y;
        oz = a.z;
        ow = a.w;
        osat = a.fx.sat | a.fy.sat | a.fz.sat | a.fw.sat;
      end
      vmt_pkg::CMD_SIMPLE, vmt_pkg::CMD_NORMAL: begin
        ox = a.x;
        oy = a.y;
        oz = a.z;
        osat = a.fx.sat | a.fy.sat | a.fz.sat;
      end
      vmt_pkg::CMD_COORD: begin
        if (a.fw.zero) begin
          ozd = 1'b1;
        end else begin
          ox = qv[0];
          oy = qv[1];
          oz = qv[2];
          osat = a.fx.sat | a.fy.sat | a.fz.sat | a.fw.sat | qs[0] | qs[1] | qs[2];
        end
      end
      default: begin
        ozd = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      res.valid <= 1'b0;
    end else if (en) begin
      res.valid <= v[D-1];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      res.out_x        <= vmt_pkg::FIELD_W'(ox);
      res.out_y        <= vmt_pkg::FIELD_W'(oy);
      res.out_z        <= vmt_pkg::FIELD_W'(oz);
      res.out_w        <= vmt_pkg::FIELD_W'(ow);
      res.zero_divisor <= ozd;
      res.saturated    <= osat;
    end
  end

endmodule

@@ hdl/vmt_lane.sv @@
// One column lane: three products and a command-chosen w term, their
// sum, rounding and clamping. Three register stages. Depends on vmt_pkg.
module vmt_lane #(
  parameter int CW = 32,
  parameter int FB = 16
) (
  input  logic                  clk,
  input  logic                  en,
  input  logic [2:0]            cmd,
  input  logic signed [CW-1:0]  vx,
  input  logic signed [CW-1:0]  vy,
  input  logic signed [CW-1:0]  vz,
  input  logic signed [CW-1:0]  vw,
  input  logic signed [CW-1:0]  c1,
  input  logic signed [CW-1:0]  c2,
  input  logic signed [CW-1:0]  c3,
  input  logic signed [CW-1:0]  c4,
  output logic signed [CW-1:0]  val,
  output vmt_pkg::lane_flags_t  flags
);

  localparam int PW = (2*CW > CW+FB+1) ? 2*CW : CW+FB+1;
  localparam int SW = PW + 2;
  localparam logic signed [SW-1:0] HALF = {{(SW-FB){1'b0}}, 1'b1, {(FB-1){1'b0}}};
  localparam logic signed [SW-1:0] MAXV = {{(SW-CW+1){1'b0}}, {(CW-1){1'b1}}};
  localparam logic signed [SW-1:0] MINV = ~MAXV;

  logic signed [2*CW-1:0] mx, my, mz, mw;
  logic signed [PW-1:0]   pw_d;
  logic signed [PW-1:0]   p0, p1, p2, p3;
  logic signed [SW-1:0]   s2;
  logic signed [SW-1:0]   rnd;
  logic signed [CW-1:0]   val_next;
  vmt_pkg::lane_flags_t   flags_next;

  assign mx = vx * c1;
  assign my = vy * c2;
  assign mz = vz * c3;
  assign mw = vw * c4;

  always_comb begin
    case (cmd)
      vmt_pkg::CMD_FULL4D: pw_d = PW'(mw);
      vmt_pkg::CMD_NORMAL: pw_d = '0;
      default:             pw_d = PW'(c4) <<< FB;
    endcase
  end

  always_comb begin
    rnd = (s2 + HALF) >>> FB;
    flags_next.zero = (rnd == '0);
    if (rnd > MAXV) begin
      val_next = MAXV[CW-1:0];
      flags_next.sat = 1'b1;
    end else if (rnd < MINV) begin
      val_next = MINV[CW-1:0];
      flags_next.sat = 1'b1;
    end else begin
      val_next = rnd[CW-1:0];
      flags_next.sat = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      p0    <= PW'(mx);
      p1    <= PW'(my);
      p2    <= PW'(mz);
      p3    <= pw_d;
      s2    <= SW'(p0) + SW'(p1) + SW'(p2) + SW'(p3);
      val   <= val_next;
      flags <= flags_next;
    end
  end

endmodule

@@ hdl/vmt_div.sv @@
// Pipelined restoring divider, one quotient bit per stage, with sign and clamp.
// Depends on nothing outside this file.
module vmt_div #(
  parameter int CW = 32,
  parameter int FB = 16
) (
  input  logic                     clk,
  input  logic                     en,
  input  logic [CW+FB:0]           num,
  input  logic [CW-1:0]            den,
  input  logic                     neg,
  output logic signed [CW-1:0]     val,
  output logic                     sat
);

  localparam int NW = CW + FB + 1;
  localparam logic signed [NW:0] MAXV = {{(NW-CW+2){1'b0}}, {(CW-1){1'b1}}};
  localparam logic signed [NW:0] MINV = ~MAXV;

  logic [CW:0]   rem [NW];
  logic [NW-1:0] nq  [NW];
  logic [CW-1:0] dn  [NW];
  logic          ng  [NW];

  generate
    for (genvar k = 0; k < NW; k++) begin : g_stage
      logic [CW:0]   rin;
      logic [NW-1:0] nin;
      logic [CW-1:0] din;
      logic          gin;
      logic [CW:0]   trial;
      logic          ge;
      if (k == 0) begin : g_first
        assign rin = '0;
        assign nin = num;
        assign din = den;
        assign gin = neg;
      end else begin : g_next
        assign rin = rem[k-1];
        assign nin = nq[k-1];
        assign din = dn[k-1];
        assign gin = ng[k-1];
      end
      assign trial = {rin[CW-1:0], nin[NW-1]};
      assign ge    = (trial >= {1'b0, din});
      always_ff @(posedge clk) begin
        if (en) begin
          rem[k] <= ge ? (trial - {1'b0, din}) : trial;
          nq[k]  <= {nin[NW-2:0], ge};
          dn[k]  <= din;
          ng[k]  <= gin;
        end
      end
    end
  endgenerate

  logic signed [NW:0] qs;
  logic signed [CW-1:0] val_next;
  logic sat_next;

  always_comb begin
    qs = ng[NW-1] ? -$signed({1'b0, nq[NW-1]}) : $signed({1'b0, nq[NW-1]});
    if (qs > MAXV) begin
      val_next = MAXV[CW-1:0];
      sat_next = 1'b1;
    end else if (qs < MINV) begin
      val_next = MINV[CW-1:0];
      sat_next = 1'b1;
    end else begin
      val_next = qs[CW-1:0];
      sat_next = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      val <= val_next;
      sat <= sat_next;
    end
  end

endmodule

@@ dv/vmt_tb_intf.sv @@
// Testbench copy of the word channel interfaces is not needed; this file
// holds nothing but a note. The block's own interfaces from hdl/vmt_intf.sv
// are instantiated directly by the testbench top.

@@ dv/vmt_checker.sv @@
// Checker for the vector matrix transform core: watches the vec and res
// channels, predicts each result word and compares. Depends on vmt_pkg and
// vmt_intf; the matrix is mirrored through a write port from the top.
module vmt_checker (
  input  logic        clk,
  input  logic        rst,
  vmt_in_if.sink      vec,
  vmt_out_if.sink     res,
  input  logic        cfg_we,
  input  logic [2:0]  cfg_idx,
  input  logic [63:0] cfg_data,
  output int          fails,
  output int          pending
);
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct {
    logic signed [31:0] x, y, z, w;
    logic zdiv, sat;
  } vertex_t;

  logic [63:0] matrix [8];
  vertex_t expected_q [$];

  function automatic longint coef(int r, int c);
    logic [63:0] v;
    logic signed [31:0] h;
    v = matrix[r * 2 + c / 2];
    h = (c % 2) ? v[63:32] : v[31:0];
    return longint'(h);
  endfunction

  function automatic longint dot_col(longint v[4], int c);
    longint p, hi, lo;
    hi = 0;
    lo = 64'sd32768;
    for (int r = 0; r < 4; r++) begin
      p = v[r] * coef(r, c);
      hi += p >>> 16;
      lo += p & 64'sh0000_0000_0000_FFFF;
    end
    return hi + (lo >>> 16);
  endfunction

  function automatic longint clamp(longint v, ref logic sat);
    if (v > 64'sd2147483647) begin
      sat = 1;
      return 64'sd2147483647;
    end
    if (v < -64'sd2147483648) begin
      sat = 1;
      return -64'sd2147483648;
    end
    return v;
  endfunction

  function automatic longint quotient(longint n, longint d, ref logic sat);
    longint un, ud, q;
    bit neg;
    neg = (n < 0) != (d < 0);
    un = (n < 0 ? -n : n) <<< 16;
    ud = d < 0 ? -d : d;
    q = (un + ud / 2) / ud;
    return clamp(neg ? -q : q, sat);
  endfunction

  function automatic vertex_t transform(logic [2:0] cmd, logic signed [31:0] x,
                                        logic signed [31:0] y, logic signed [31:0] z,
                                        logic signed [31:0] w);
    vertex_t o;
    longint v[4], r[4], ws;
    logic sat;
    sat = 0;
    r = '{0, 0, 0, 0};
    o.zdiv = 0;
    v[0] = longint'(x);
    v[1] = longint'(y);
    v[2] = longint'(z);
    v[3] = (cmd == vmt_pkg::CMD_FULL4D) ? longint'(w) :
           (cmd == vmt_pkg::CMD_NORMAL) ? 64'sd0 : 64'sd65536;
    case (cmd)
      vmt_pkg::CMD_FULL3D, vmt_pkg::CMD_FULL4D:
        for (int c = 0; c < 4; c++) r[c] = clamp(dot_col(v, c), sat);
      vmt_pkg::CMD_SIMPLE, vmt_pkg::CMD_NORMAL:
        for (int c = 0; c < 3; c++) r[c] = clamp(dot_col(v, c), sat);
      vmt_pkg::CMD_COORD: begin
        ws = dot_col(v, 3);
        if (ws == 0) o.zdiv = 1;
        else begin
          ws = clamp(ws, sat);
          for (int c = 0; c < 3; c++) r[c] = quotient(clamp(dot_col(v, c), sat), ws, sat);
        end
      end
      default: ;
    endcase
    o.x = 32'(r[0]);
    o.y = 32'(r[1]);
    o.z = 32'(r[2]);
    o.w = 32'(r[3]);
    o.sat = sat;
    return o;
  endfunction

  assign pending = expected_q.size();

  always @(posedge clk) begin
    vertex_t e;
    if (rst) begin
      foreach (matrix[i]) matrix[i] <= vmt_pkg::CFG_RESET[i];
      fails <= 0;
    end else begin
      if (cfg_we) matrix[cfg_idx] <= cfg_data;
      if (vec.valid && vec.ready)
        expected_q.push_back(transform(vec.command, vec.vec_x, vec.vec_y, vec.vec_z,
                                       vec.vec_w));
      if (res.valid && res.ready) begin
        if (expected_q.size() == 0) begin
          $error("result word with nothing expected");
          fails <= fails + 1;
        end else begin
          e = expected_q.pop_front();
          if (e.x !== res.out_x || e.y !== res.out_y || e.z !== res.out_z ||
              e.w !== res.out_w || e.zdiv !== res.zero_divisor ||
              e.sat !== res.saturated) begin
            if (e.x !== res.out_x) $error("out_x exp %0d got %0d", e.x, res.out_x);
            if (e.y !== res.out_y) $error("out_y exp %0d got %0d", e.y, res.out_y);
            if (e.z !== res.out_z) $error("out_z exp %0d got %0d", e.z, res.out_z);
            if (e.w !== res.out_w) $error("out_w exp %0d got %0d", e.w, res.out_w);
            if (e.zdiv !== res.zero_divisor)
              $error("zero_divisor exp %0b got %0b", e.zdiv, res.zero_divisor);
            if (e.sat !== res.saturated)
              $error("saturated exp %0b got %0b", e.sat, res.saturated);
            fails <= fails + 1;
          end
        end
      end
    end
  end
endmodule

@@ dv/vector_matrix_transform_core_tb.sv @@
// Testbench top for the vector matrix transform core: drives vector words
// and matrix writes over APB, with random idling; checking is in vmt_checker.
// Depends on vmt_pkg, vmt_intf, vmt_checker and the core.
module vector_matrix_transform_core_tb;
  timeunit 1ns;
  timeprecision 1ps;

  logic clk = 0, rst = 1;
  logic psel = 0, penable = 0, pwrite = 0;
  logic [vmt_pkg::CFG_ADDR_W-1:0] paddr = '0;
  logic [vmt_pkg::CFG_DATA_W-1:0] pwdata = '0, prdata;
  logic pready, cfg_we;
  int fails, pending;
  bit quiet = 0;

  vmt_in_if vec ();
  vmt_out_if res ();

  vector_matrix_transform_core i_dut (.clk, .rst, .vec(vec.sink), .res(res.source),
    .psel, .penable, .pwrite, .paddr, .pwdata, .prdata, .pready);

  assign cfg_we = psel && penable && pwrite && pready;

  vmt_checker i_checker (.clk, .rst, .vec(vec.sink), .res(res.sink), .cfg_we,
    .cfg_idx(paddr[5:3]), .cfg_data(pwdata), .fails, .pending);

  initial forever #5 clk = ~clk;

  initial begin
    #20ms;
    $display("FAILURE");
    $finish;
  end

  initial begin
    res.ready = 0;
    @(posedge clk iff !rst);
    forever begin
      if (!quiet && $urandom_range(5) == 0) begin
        res.ready <= 0;
        repeat ($urandom_range(1, 4)) @(posedge clk);
      end
      res.ready <= 1;
      @(posedge clk);
    end
  end

  function automatic logic [31:0] rand_comp(int mode);
    case (mode)
      0: return $urandom;
      1: return $urandom_range(0, 1) ? 32'h7FFF_FFFF : 32'h8000_0000;
      2: return 32'(int'($urandom_range(0, 8 << 16)) - (4 << 16));
      default: return {{16{1'b0}}, 16'($urandom)} ^ ($urandom_range(0, 1) ? '1 : '0);
    endcase
  endfunction

  task automatic send_word(logic [2:0] cmd, logic [31:0] x, y, z, w);
    if (!quiet && $urandom_range(4) == 0) begin
      vec.valid <= 0;
      repeat ($urandom_range(1, 4)) @(posedge clk);
    end
    vec.valid <= 1;
    vec.command <= cmd;
    vec.vec_x <= x; vec.vec_y <= y; vec.vec_z <= z; vec.vec_w <= w;
    @(posedge clk);
    while (!vec.ready) @(posedge clk);
  endtask

  task automatic drain;
    vec.valid <= 0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (60) @(posedge clk);
  endtask

  task automatic write_row(int idx, logic [63:0] data);
    psel <= 1; penable <= 0; pwrite <= 1;
    paddr <= vmt_pkg::CFG_ADDR_W'(idx * 8); pwdata <= data;
    @(posedge clk);
    penable <= 1;
    @(posedge clk);
    psel <= 0; penable <= 0; pwrite <= 0;
    @(posedge clk);
  endtask

  function automatic logic [31:0] rand_coef(int style);
    case (style)
      0: return 32'(int'($urandom_range(0, 4 << 16)) - (2 << 16));
      1: return $urandom;
      default: return $urandom_range(0, 1) ? 32'h7FFF_FFFF : 32'h8000_0000;
    endcase
  endfunction

  initial begin
    logic [2:0] cmd;
    int m;
    vec.valid = 0; vec.command = '0;
    vec.vec_x = '0; vec.vec_y = '0; vec.vec_z = '0; vec.vec_w = '0;
    repeat (4) @(posedge clk);
    rst <= 0;
    @(posedge clk);
    for (int c = 0; c < 8; c++) begin
      send_word(3'(c), 32'h7FFF_FFFF, 32'h8000_0000, 32'h0001_0000, 32'hFFFF_0000);
      send_word(3'(c), 32'h8000_0000, 32'h7FFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF);
    end
    send_word(vmt_pkg::CMD_COORD, 32'h0001_0000, 32'h0002_0000, 32'h0, 32'h0);
    drain();
    write_row(7, '0);
    send_word(vmt_pkg::CMD_COORD, 32'h0001_0000, 32'h0002_0000, 32'h0003_0000, 32'h0);
    send_word(vmt_pkg::CMD_COORD, 32'h0, 32'h0, 32'h0, 32'h0);
    drain();
    write_row(7, {32'h0000_0001, 32'h0});
    send_word(vmt_pkg::CMD_COORD, 32'h7FFF_FFFF, 32'h8000_0000, 32'h0001_0000, 32'h0);
    drain();
    for (int ph = 0; ph < 8; ph++) begin
      for (int i = 0; i < 8; i++)
        write_row(i, ph == 7 ? 64'hFFFF_FFFF_FFFF_FFFF :
                     ph == 6 ? 64'h0 :
                     {rand_coef(ph % 3), rand_coef(ph % 3)});
      if (ph == 6) write_row(7, {32'h0, 32'h0});
      for (int i = 0; i < 75; i++) begin
        if (ph == 7 && i == 40) quiet = 1;
        cmd = $urandom_range(0, 9) == 0 ? 3'($urandom_range(5, 7)) : 3'($urandom_range(0, 4));
        m = $urandom_range(0, 3);
        send_word(cmd, rand_comp(m), rand_comp(m), rand_comp(m), rand_comp(m));
      end
      drain();
    end
    for (int i = 0; i < 8; i++) write_row(i, vmt_pkg::CFG_RESET[i]);
    if (fails == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end
endmodule

@@ files.f @@
hdl/vmt_pkg.sv
hdl/vmt_intf.sv
hdl/vmt_lane.sv
hdl/vmt_div.sv
hdl/vector_matrix_transform_core.sv
dv/vmt_tb_intf.sv
dv/vmt_checker.sv
dv/vector_matrix_transform_core_tb.sv
